@@ rtl/core/wsdf_pkg.sv @@
package wsdf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } wsdf_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start_load;
        logic start_query;
        logic scan_step;
        logic scan_last;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic finish;
    } wsdf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic query_ok;
        logic scan_done;
        logic sqrt_done;
        logic div_done;
    } wsdf_stat_t;

    localparam int unsigned SqrtSteps = 21;
    localparam int unsigned DivSteps  = 21;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgRadius = 2'd2;

endpackage

@@ rtl/core/wsdf_ctrl.sv @@
module wsdf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               in_query,
    input  logic               out_free,
    input  wsdf_pkg::wsdf_stat_t stat,
    output wsdf_pkg::wsdf_cmd_t  cmd,
    output logic               busy
);
    import wsdf_pkg::*;

    wsdf_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    if (in_query) begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_SCAN;
                    end else begin
                        cmd.start_load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!stat.query_ok) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_done) begin
                        cmd.scan_last = 1'b1;
                        state_next    = ST_DRAIN;
                        cnt_next      = 5'd0;
                    end
                end
            end
            ST_DRAIN: begin
                // memory read and compare pipeline empties
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/core/wsdf_datapath.sv @@
module wsdf_datapath #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    parameter int unsigned MAX_RADIUS = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wsdf_pkg::wsdf_cmd_t  cmd,
    output wsdf_pkg::wsdf_stat_t stat,
    input  logic [7:0]         in_x,
    input  logic [7:0]         in_y,
    input  logic [1:0]         in_marks,
    input  logic [8:0]         cfg_width,
    input  logic [8:0]         cfg_height,
    input  logic [4:0]         cfg_radius,
    output logic [7:0]         sdf_value,
    output logic [9:0]         nearest_sq
);
    import wsdf_pkg::*;

    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int Depth = 1 << (XW + YW);

    // Pixel mark memory, addressed by {row, column}
    logic [1:0] mem [Depth];
    logic [1:0] rd_reg;

    // Effective geometry (signed 11 bit coordinates)
    logic [8:0]  w_eff, h_eff;
    logic [4:0]  r_eff;
    always_comb begin
        w_eff = (32'(cfg_width)  > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : cfg_width;
        h_eff = (32'(cfg_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_height;
        r_eff = (32'(cfg_radius) > MAX_RADIUS) ? 5'(MAX_RADIUS) : cfg_radius;
    end

    logic [7:0]  qx_reg, qy_reg;
    logic [4:0]  r_reg;
    logic [8:0]  w_reg, h_reg;
    logic        ok_reg;
    logic signed [10:0] sx_reg, sy_reg;

    logic signed [10:0] xmin, xmax, ymin, ymax;
    always_comb begin
        xmin = $signed({3'b0, qx_reg}) - $signed({6'b0, r_reg});
        xmax = $signed({3'b0, qx_reg}) + $signed({6'b0, r_reg});
        ymin = $signed({3'b0, qy_reg}) - $signed({6'b0, r_reg});
        ymax = $signed({3'b0, qy_reg}) + $signed({6'b0, r_reg});
        if (xmin < 0) xmin = '0;
        if (ymin < 0) ymin = '0;
        if (xmax > $signed({2'b0, w_reg}) - 11'sd1) xmax = $signed({2'b0, w_reg}) - 11'sd1;
        if (ymax > $signed({2'b0, h_reg}) - 11'sd1) ymax = $signed({2'b0, h_reg}) - 11'sd1;
    end

    // Window start for the query being accepted
    logic signed [10:0] nx_lo, ny_lo;
    always_comb begin
        nx_lo = $signed({3'b0, in_x}) - $signed({6'b0, r_eff});
        ny_lo = $signed({3'b0, in_y}) - $signed({6'b0, r_eff});
        if (nx_lo < 0) nx_lo = '0;
        if (ny_lo < 0) ny_lo = '0;
    end

    assign stat.query_ok    = ok_reg;
    assign stat.scan_done   = (sx_reg == xmax) && (sy_reg == ymax);

    // Scan walker and memory access
    logic        rdv_reg, center_reg;
    logic [4:0]  adx_reg, ady_reg;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [10:0] ddx, ddy;
    always_comb begin
        ax  = cmd.start_load ? XW'(in_x) : XW'(sx_reg);
        ay  = cmd.start_load ? YW'(in_y) : YW'(sy_reg);
        ddx = 11'(sx_reg - $signed({3'b0, qx_reg}));
        ddy = 11'(sy_reg - $signed({3'b0, qy_reg}));
        if (ddx[10]) ddx = 11'(-$signed(ddx));
        if (ddy[10]) ddy = 11'(-$signed(ddy));
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_load && (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT))
            mem[{ay, ax}] <= in_marks;
        rd_reg <= mem[{ay, ax}];
    end

    logic [9:0]  d_reg;
    logic        in_reg;
    logic [10:0] cand;
    assign cand = 11'(adx_reg) * 11'(adx_reg) + 11'(ady_reg) * 11'(ady_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg  <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            rdv_reg <= cmd.scan_step;
            if (cmd.start_query)
                ok_reg <= (9'(in_x) < w_eff) && (9'(in_y) < h_eff);
        end
        if (cmd.start_query) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
            r_reg  <= r_eff;
            w_reg  <= w_eff;
            h_reg  <= h_eff;
            d_reg  <= 10'(r_eff) * 10'(r_eff);
        end
        if (cmd.start_query) begin
            sx_reg <= nx_lo;
            sy_reg <= ny_lo;
        end else if (cmd.scan_step && !cmd.scan_last) begin
            if (sx_reg == xmax) begin
                sx_reg <= xmin;
                sy_reg <= sy_reg + 11'sd1;
            end else begin
                sx_reg <= sx_reg + 11'sd1;
            end
        end
        // stage 1: capture offsets with the read
        adx_reg    <= ddx[4:0];
        ady_reg    <= ddy[4:0];
        center_reg <= (ddx == '0) && (ddy == '0);
        // stage 2: compare
        if (rdv_reg) begin
            if (center_reg) in_reg <= rd_reg[1];
            if (rd_reg[0] && (cand < {1'b0, d_reg})) d_reg <= cand[9:0];
        end
    end

    // Square root of d * 2^32, one result bit per step (21 bits)
    logic [20:0] root_reg;
    logic [4:0]  sc_reg;
    logic [22:0] tr;
    assign tr = {root_reg, 2'b01};
    logic [41:0] rad_reg;
    logic [22:0] prem_reg;

    assign stat.sqrt_done = (sc_reg == 5'(SqrtSteps - 1));

    // Divider: quotient = root / r, restoring, one bit per step
    logic [20:0] dq_reg;
    logic [5:0]  dr_reg;
    logic [4:0]  dc_reg;
    logic [5:0]  dr_sh;
    assign dr_sh = {dr_reg[4:0], dq_reg[20]};
    assign stat.div_done = (dc_reg == 5'(DivSteps - 1));

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            rad_reg  <= {d_reg, 32'b0};
            prem_reg <= '0;
            root_reg <= '0;
            sc_reg   <= '0;
        end else if (cmd.sqrt_step) begin
            if ({prem_reg[20:0], rad_reg[41:40]} >= tr) begin
                prem_reg <= {prem_reg[20:0], rad_reg[41:40]} - tr;
                root_reg <= {root_reg[19:0], 1'b1};
            end else begin
                prem_reg <= {prem_reg[20:0], rad_reg[41:40]};
                root_reg <= {root_reg[19:0], 1'b0};
            end
            rad_reg <= {rad_reg[39:0], 2'b00};
            sc_reg  <= sc_reg + 5'd1;
        end
        if (cmd.div_start) begin
            dq_reg <= (cmd.sqrt_step && ({prem_reg[20:0], rad_reg[41:40]} >= tr))
                      ? {root_reg[19:0], 1'b1} : {root_reg[19:0], 1'b0};
            dr_reg <= '0;
            dc_reg <= '0;
        end else if (cmd.div_step) begin
            if (dr_sh >= {1'b0, r_reg}) begin
                dr_reg <= dr_sh - {1'b0, r_reg};
                dq_reg <= {dq_reg[19:0], 1'b1};
            end else begin
                dr_reg <= dr_sh;
                dq_reg <= {dq_reg[19:0], 1'b0};
            end
            dc_reg <= dc_reg + 5'd1;
        end
    end

    // Final encode
    logic [16:0] q;
    logic [17:0] z17;
    logic [25:0] prod;
    always_comb begin
        q = (r_reg == 5'd0 || dq_reg > 21'd65536) ? 17'd65536 : dq_reg[16:0];
        z17 = in_reg ? (18'd65536 - 18'(q)) : (18'd65536 + 18'(q));
        prod = 26'(z17) * 26'd255;
        sdf_value  = 8'(9'd255 - 9'(prod[25:17]));
        nearest_sq = d_reg;
    end

endmodule

@@ rtl/core/windowed_signed_distance_field_unit.sv @@
// Windowed signed distance field unit. Load transfers (action 0) write one
// pixel's edge and inside marks. A query transfer scans the clipped
// (2R+1)x(2R+1) window one pixel per cycle through the single mark memory
// port, then runs a square root and a divide; s_tready stays low until the
// result is taken into the output register, which waits while an earlier
// result stalls on m_tready. Queries outside the image give no result.
// Every pixel must be loaded before it is read by a query; the mark memory
// has no reset.
module windowed_signed_distance_field_unit #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    parameter int unsigned MAX_RADIUS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_x, pixel_y, edge_mark, inside_mark
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sdf_value, nearest_squared_distance
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import wsdf_pkg::*;

    wsdf_cmd_t  cmd;
    wsdf_stat_t stat;
    logic       busy;
    logic [8:0] width_reg, height_reg;
    logic [4:0] radius_reg;
    logic [7:0] sdf;
    logic [9:0] nsq;
    logic       mv_reg;
    logic [17:0] mdata_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 5'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                CfgWidth:  width_reg  <= cfg_data;
                CfgHeight: height_reg <= cfg_data;
                CfgRadius: radius_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    wsdf_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire (s_tvalid && s_tready),
        .in_query(s_tuser),
        .out_free(!mv_reg || m_tready),
        .stat, .cmd, .busy
    );

    wsdf_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_x(s_tdata[7:0]), .in_y(s_tdata[15:8]), .in_marks(s_tdata[17:16]),
        .cfg_width(width_reg), .cfg_height(height_reg), .cfg_radius(radius_reg),
        .sdf_value(sdf), .nearest_sq(nsq)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.finish) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
        if (cmd.finish) mdata_reg <= {nsq, sdf};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'b0, mdata_reg};

endmodule

@@ rtl/core/wsdf_checker.sv @@
module wsdf_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // a stalled result keeps its valid and data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    // padding above the result fields stays clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("padding bits set");
    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    // a query transfer holds off the input on the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input accepted during a query");
endmodule

bind windowed_signed_distance_field_unit wsdf_port_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .m_tvalid, .m_tready, .m_tdata
);
